@@ sv/rsvpe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsvpe_pkg: shared definitions of the vandermonde parity encoder
// Field arithmetic over GF(2^8), register map and defaults, chain control.
// ----------------------------------------------------------------------------
package rsvpe_pkg;

   // low byte of the field polynomial x^8+x^4+x^3+x^2+1
   localparam logic [7:0] FIELD_POLY_LOW = 8'h1D;

   // sizing defaults for the top level parameters
   localparam int MAX_NATIVE_DEF = 32;
   localparam int MAX_PARITY_DEF = 8;

   // register widths and reset values
   localparam int NATIVE_W = 6;
   localparam int PARITY_W = 4;
   localparam logic [NATIVE_W-1:0] NATIVE_RESET = 6'd4;
   localparam logic [PARITY_W-1:0] PARITY_RESET = 4'd2;

   // register indexes on the control port (index = paddr[2])
   localparam logic REG_NATIVE_COUNT = 1'b0;
   localparam logic REG_PARITY_COUNT = 1'b1;

   // control that travels with each word along the cell chain
   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

   // GF(2^8) product, shift and add over the eight bits of b
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] x;
      logic [7:0] acc;
      x   = a;
      acc = '0;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            acc = acc ^ x;
         end
         x = x[7] ? ({x[6:0], 1'b0} ^ FIELD_POLY_LOW) : {x[6:0], 1'b0};
      end
      return acc;
   endfunction

endpackage

@@ sv/rsvpe_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsvpe_cell: one parity row of the encoder chain
// Holds the row accumulator, folds in d*coef for each passing word, hands the
// word on with coef*base, and drops the finished byte into the result slot.
// ----------------------------------------------------------------------------
module rsvpe_cell #(
   parameter int MAX_PARITY = rsvpe_pkg::MAX_PARITY_DEF,
   parameter int ROW        = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  rsvpe_pkg::ctl_type           in_ctl,
   input  logic [7:0]                   in_data,
   input  logic [7:0]                   in_base,
   input  logic [7:0]                   in_coef,
   input  logic [MAX_PARITY-1:0][7:0]   in_res,
   output rsvpe_pkg::ctl_type           out_ctl,
   output logic [7:0]                   out_data,
   output logic [7:0]                   out_base,
   output logic [7:0]                   out_coef,
   output logic [MAX_PARITY-1:0][7:0]   out_res
);

   rsvpe_pkg::ctl_type         ctl_ff;
   logic [7:0]                 acc_ff;
   logic [7:0]                 acc_in;
   logic [7:0]                 data_ff;
   logic [7:0]                 base_ff;
   logic [7:0]                 coef_ff;
   logic [7:0]                 coef_in;
   logic [MAX_PARITY-1:0][7:0] res_ff;
   logic [MAX_PARITY-1:0][7:0] res_in;
   logic [7:0]                 fin;

   // row update and next coefficient
   always_comb begin
      fin     = acc_ff ^ rsvpe_pkg::gf_mul(in_data, in_coef);
      acc_in  = in_ctl.last ? 8'h00 : fin;
      coef_in = rsvpe_pkg::gf_mul(in_coef, in_base);
      res_in      = in_res;
      res_in[ROW] = fin;
   end

   // control and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
         acc_ff <= '0;
      end else if (adv) begin
         ctl_ff <= in_ctl;
         if (in_ctl.valid) begin
            acc_ff <= acc_in;
         end
      end
   end

   // word handed to the next cell
   always_ff @(posedge clock) begin
      if (adv && in_ctl.valid) begin
         data_ff <= in_data;
         base_ff <= in_base;
         coef_ff <= coef_in;
         res_ff  <= res_in;
      end
   end

   assign out_ctl  = ctl_ff;
   assign out_data = data_ff;
   assign out_base = base_ff;
   assign out_coef = coef_ff;
   assign out_res  = res_ff;

endmodule

@@ sv/rsvpe_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsvpe_out: parity output bank
// Takes the finished parity bytes of a position from the chain tail and sends
// them out row by row, flagging the last one.
// ----------------------------------------------------------------------------
module rsvpe_out #(
   parameter int MAX_PARITY = rsvpe_pkg::MAX_PARITY_DEF,
   parameter int ROW_W      = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic [MAX_PARITY-1:0][7:0]  load_res,
   input  logic [ROW_W-1:0]            last_row,
   output logic                        bank_free,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [7:0]                  rsp_parity_byte,
   output logic [2:0]                  rsp_parity_row,
   output logic                        rsp_last_of_run
);

   logic                       busy_ff;
   logic [ROW_W-1:0]           row_ff;
   logic [MAX_PARITY-1:0][7:0] bank_ff;
   logic                       fire;
   logic                       at_last;

   assign at_last   = (row_ff == last_row);
   assign fire      = busy_ff && rsp_ready;
   assign bank_free = !busy_ff || (fire && at_last);

   // bank state and row counter
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         row_ff  <= '0;
      end else if (fire) begin
         if (at_last) begin
            busy_ff <= 1'b0;
         end
         row_ff <= row_ff + ROW_W'(1);
      end
   end

   // bank shifts down one byte per word sent
   always_ff @(posedge clock) begin
      if (load) begin
         bank_ff <= load_res;
      end else if (fire) begin
         for (int j = 0; j < MAX_PARITY - 1; j++) begin
            bank_ff[j] <= bank_ff[j+1];
         end
      end
   end

   assign rsp_valid       = busy_ff;
   assign rsp_parity_byte = bank_ff[0];
   assign rsp_parity_row  = 3'(row_ff);
   assign rsp_last_of_run = at_last;

endmodule

@@ sv/rs_vandermonde_parity_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs_vandermonde_parity_encoder: GF(2^8) vandermonde erasure parity encoder
// Data bytes of one stripe position come in native block order on req_; after
// the last native byte the parity bytes of rows 0..parity_count-1 go out on
// rsp_, the last one flagged. Registers sit on the csr_ port: native_count at
// address 0, parity_count at address 4.
// Each parity row is a cell of a chain; while the chain is not stalled a word
// moves one cell per cycle, so one byte is accepted every cycle. A position's
// first parity byte is valid once it is loaded into the output bank, then one
// byte per cycle while rsp_ready is high. The output bank holds one position;
// while it drains, the chain keeps taking bytes, and it stalls (req_ready low)
// only when a finished position reaches the chain tail with the bank still
// full. Sustained rate is one byte per cycle as long as parity_count does not
// exceed native_count; otherwise it is set by the output at one parity byte a
// cycle. Reset empties chain and bank, clears all accumulators, the block
// position and loads the default counts (4 native, 2 parity).
// ----------------------------------------------------------------------------
module rs_vandermonde_parity_encoder #(
   parameter int MAX_NATIVE = rsvpe_pkg::MAX_NATIVE_DEF,
   parameter int MAX_PARITY = rsvpe_pkg::MAX_PARITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_parity_byte,
   output logic [2:0]  rsp_parity_row,
   output logic        rsp_last_of_run,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int POS_W = (MAX_NATIVE > 1) ? $clog2(MAX_NATIVE) : 1;
   localparam int ROW_W = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
   localparam int CNT_W = 9;
   localparam int PCNT_W = 8;

   logic [rsvpe_pkg::NATIVE_W-1:0] native_count_ff;
   logic [rsvpe_pkg::PARITY_W-1:0] parity_count_ff;
   logic [POS_W-1:0]               pos_ff;
   logic [CNT_W-1:0]               n_raw;
   logic [CNT_W-1:0]               n_eff;
   logic [PCNT_W-1:0]              p_raw;
   logic [PCNT_W-1:0]              p_eff;
   logic                           end_pos;
   logic                           adv;
   logic                           accept;
   logic                           tail_done;
   logic                           bank_free;
   logic                           load;
   logic                           csr_write;

   rsvpe_pkg::ctl_type         chain_ctl  [MAX_PARITY+1];
   logic [7:0]                 chain_data [MAX_PARITY+1];
   logic [7:0]                 chain_base [MAX_PARITY+1];
   logic [7:0]                 chain_coef [MAX_PARITY+1];
   logic [MAX_PARITY-1:0][7:0] chain_res  [MAX_PARITY+1];

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         native_count_ff <= rsvpe_pkg::NATIVE_RESET;
         parity_count_ff <= rsvpe_pkg::PARITY_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            rsvpe_pkg::REG_NATIVE_COUNT: begin
               native_count_ff <= csr_pwdata[rsvpe_pkg::NATIVE_W-1:0];
            end
            rsvpe_pkg::REG_PARITY_COUNT: begin
               parity_count_ff <= csr_pwdata[rsvpe_pkg::PARITY_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         rsvpe_pkg::REG_NATIVE_COUNT: csr_prdata = 32'(native_count_ff);
         rsvpe_pkg::REG_PARITY_COUNT: csr_prdata = 32'(parity_count_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // counts saturated into their usable ranges
   always_comb begin
      n_raw = CNT_W'(native_count_ff);
      if (n_raw == '0) begin
         n_eff = CNT_W'(1);
      end else if (n_raw > CNT_W'(MAX_NATIVE)) begin
         n_eff = CNT_W'(MAX_NATIVE);
      end else begin
         n_eff = n_raw;
      end
      p_raw = PCNT_W'(parity_count_ff);
      if (p_raw == '0) begin
         p_eff = PCNT_W'(1);
      end else if (p_raw > PCNT_W'(MAX_PARITY)) begin
         p_eff = PCNT_W'(MAX_PARITY);
      end else begin
         p_eff = p_raw;
      end
   end

   // chain stalls only when a finished position waits on a full bank
   assign tail_done = chain_ctl[MAX_PARITY].valid && chain_ctl[MAX_PARITY].last;
   assign adv       = !tail_done || bank_free;
   assign load      = tail_done && bank_free;
   assign req_ready = adv;
   assign accept    = req_valid && req_ready;
   assign end_pos   = (CNT_W'(pos_ff) + CNT_W'(1)) >= n_eff;

   // native block position
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (accept) begin
         pos_ff <= end_pos ? '0 : pos_ff + POS_W'(1);
      end
   end

   // word entering the first cell
   assign chain_ctl[0].valid = accept;
   assign chain_ctl[0].last  = end_pos;
   assign chain_data[0]      = req_data_byte;
   assign chain_base[0]      = 8'(CNT_W'(pos_ff) + CNT_W'(1));
   assign chain_coef[0]      = 8'h01;
   assign chain_res[0]       = '0;

   // one cell per parity row
   for (genvar i = 0; i < MAX_PARITY; i++) begin : g_cell
      rsvpe_cell #(
         .MAX_PARITY (MAX_PARITY),
         .ROW        (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_ctl   (chain_ctl[i]),
         .in_data  (chain_data[i]),
         .in_base  (chain_base[i]),
         .in_coef  (chain_coef[i]),
         .in_res   (chain_res[i]),
         .out_ctl  (chain_ctl[i+1]),
         .out_data (chain_data[i+1]),
         .out_base (chain_base[i+1]),
         .out_coef (chain_coef[i+1]),
         .out_res  (chain_res[i+1])
      );
   end

   // output bank
   rsvpe_out #(
      .MAX_PARITY (MAX_PARITY),
      .ROW_W      (ROW_W)
   ) u_out (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .load_res        (chain_res[MAX_PARITY]),
      .last_row        (ROW_W'(p_eff - PCNT_W'(1))),
      .bank_free       (bank_free),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_parity_byte (rsp_parity_byte),
      .rsp_parity_row  (rsp_parity_row),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // input stalls only behind a full output bank
   a_stall_needs_bank: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && tail_done)
      else $error("input stalled with no parity pending");

   // every position starts at row zero
   a_first_row: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid && rsp_parity_row == 3'd0)
      else $error("parity run does not start at row zero");

   // bank empties after its last word unless refilled
   a_bank_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_of_run && !load |=> !rsp_valid)
      else $error("parity bank not released after last word");

   // block position stays inside the stripe
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(pos_ff) < CNT_W'(MAX_NATIVE))
      else $error("native position out of range");

   // a stalled finished position stays at the tail
   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      tail_done && !adv |=> tail_done)
      else $error("finished position lost at chain tail");

endmodule
